// ----- hdl/sfl_pkg.sv -----
// Shared types and constants for the segment free-list allocator.
package sfl_pkg;

  localparam int LEN_W = 17;
  localparam logic [LEN_W-1:0] LEN_MAX = 17'h1FFFF;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_COMPACT = 2'd2;
  localparam logic [1:0] CMD_INIT    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_COMPACT = 2'd1;
  localparam logic [1:0] ST_NOMEM   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] FIRST = 2'd0;
  localparam logic [1:0] BEST  = 2'd1;
  localparam logic [1:0] WORST = 2'd2;

  localparam logic [1:0] CFG_POLICY   = 2'd0;
  localparam logic [1:0] CFG_MEM_SIZE = 2'd1;
  localparam logic [1:0] CFG_RES_SIZE = 2'd2;

  localparam logic [LEN_W-1:0] MEM_SIZE_RST = 17'd4096;
  localparam logic [LEN_W-1:0] RES_SIZE_RST = 17'd128;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic start_scan;
    logic scan;
    logic decide;
    logic simple;
    logic shift_dn;
    logic shift_up;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       zero_size;
    logic       scan_done;
    logic       go_drop;
    logic       go_open;
    logic       shift_done;
    logic       out_free;
  } sts_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W:0] v);
    sat_len = v[LEN_W] ? LEN_MAX : v[LEN_W-1:0];
  endfunction

endpackage

// ----- hdl/sfl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sfl_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/sfl_ctrl.sv -----
// Sequencing state machine for the allocator.
module sfl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfl_pkg::sts_t sts,
  output sfl_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DISP   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_DROP   = 7'b0010000,
    S_OPEN   = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op) inside
          sfl_pkg::CMD_ALLOC, sfl_pkg::CMD_RELEASE: begin
            if (sts.zero_size) begin
              state_next = S_FIN;
            end else begin
              cmd.start_scan = 1'b1;
              state_next     = S_SCAN;
            end
          end
          sfl_pkg::CMD_COMPACT, sfl_pkg::CMD_INIT: begin
            cmd.simple = 1'b1;
            state_next = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.go_drop) begin
          state_next = S_DROP;
        end else if (sts.go_open) begin
          state_next = S_OPEN;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DROP: begin
        cmd.shift_dn = 1'b1;
        if (sts.shift_done) begin
          state_next = S_FIN;
        end
      end
      S_OPEN: begin
        cmd.shift_up = 1'b1;
        if (sts.shift_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/sfl_dp.sv -----
// Datapath: hole table, counters, fit search, merge and shift logic.
module sfl_dp #(
  parameter int FREE_SLOTS = 32,
  parameter int ADDR_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  sfl_pkg::cmd_t cmd,
  output sfl_pkg::sts_t sts,
  input  logic [1:0]    in_command,
  input  logic [16:0]   in_size,
  input  logic [15:0]   in_base,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [16:0]   cfg_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [15:0]   out_granted,
  output logic [16:0]   out_total
);

  localparam int LW = sfl_pkg::LEN_W;
  localparam int AB = ADDR_BITS;
  localparam int EW = LW + AB;
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int IW = $clog2(FREE_SLOTS);
  localparam int SW = ((AB > LW) ? AB : LW) + 1;
  localparam logic [32:0] AMASK = (33'd1 << ADDR_BITS) - 33'd1;
  localparam logic [CW-1:0] SLOTS = CW'(FREE_SLOTS);

  // configuration
  logic [1:0]    policy;
  logic [LW-1:0] mem_size, res_size;

  // table state
  logic [CW-1:0] count;
  logic [LW-1:0] total;

  // current item
  logic [1:0]    cmd_r;
  logic [LW-1:0] size_r;
  logic [AB-1:0] base_r;

  // scan / shift state
  logic [CW-1:0] idx, rd_idx, sh_idx, pick_idx, p;
  logic          rd_valid, sh_more, found, stopped;
  logic [AB-1:0] pick_base, prev_base, next_base;
  logic [LW-1:0] pick_len, prev_len, next_len;
  logic [1:0]    status_r;
  logic [15:0]   granted_r;

  // ram
  logic          we;
  logic [CW-1:0] waddr_w;
  logic [EW-1:0] wdata, rdata;
  logic [IW-1:0] raddr;
  logic [AB-1:0] e_base;
  logic [LW-1:0] e_len;

  logic scan_issue, dn_issue, up_issue, rd_issue;
  logic jp, jn, have_next, rel_ok, carve, better;
  logic [LW-1:0] l1, merged_len, jn_len, alloc_total;
  logic [AB-1:0] carve_base, compact_base;
  logic init_ok;
  logic [31:0] pick_base_w;

  sfl_ram #(.WIDTH(EW), .DEPTH(FREE_SLOTS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr_w[IW-1:0]),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign e_base = rdata[AB-1:0];
  assign e_len  = rdata[EW-1:AB];

  assign scan_issue = cmd.scan && (idx < count);
  assign dn_issue   = cmd.shift_dn && sh_more;
  assign up_issue   = cmd.shift_up && sh_more;
  assign rd_issue   = scan_issue || dn_issue || up_issue;
  assign raddr      = scan_issue ? idx[IW-1:0] : sh_idx[IW-1:0];

  // merge / fit decisions
  always_comb begin
    have_next  = p < count;
    jp         = (p != '0) && (SW'(prev_base) + SW'(prev_len) == SW'(base_r));
    jn         = have_next && (SW'(base_r) + SW'(size_r) == SW'(next_base));
    rel_ok     = jp || jn || (count < SLOTS);
    l1         = sfl_pkg::sat_len({1'b0, prev_len} + {1'b0, size_r});
    merged_len = jn ? sfl_pkg::sat_len({1'b0, l1} + {1'b0, next_len}) : l1;
    jn_len     = sfl_pkg::sat_len({1'b0, size_r} + {1'b0, next_len});
    carve      = pick_len > size_r;
    carve_base = AB'(SW'(pick_base) + SW'(size_r));
    alloc_total = (total >= size_r) ? total - size_r : '0;
    compact_base = (mem_size > total) ? AB'(mem_size - total) : '0;
    init_ok    = (mem_size > res_size) && ({16'b0, res_size} <= AMASK);
    pick_base_w = 32'(pick_base);
    if (!found) begin
      better = 1'b1;
    end else if (policy == sfl_pkg::BEST) begin
      better = e_len < pick_len;
    end else if (policy == sfl_pkg::WORST) begin
      better = e_len >= pick_len;
    end else begin
      better = 1'b0;
    end
  end

  always_comb begin
    sts.op         = cmd_r;
    sts.zero_size  = size_r == '0;
    sts.scan_done  = !(idx < count) && !rd_valid;
    sts.shift_done = !sh_more && !rd_valid;
    sts.out_free   = !out_valid || out_ready;
    if (cmd_r == sfl_pkg::CMD_ALLOC) begin
      sts.go_drop = found && !carve;
      sts.go_open = 1'b0;
    end else begin
      sts.go_drop = rel_ok && jp && jn;
      sts.go_open = rel_ok && !jp && !jn;
    end
  end

  // single write port
  always_comb begin
    we      = 1'b0;
    waddr_w = '0;
    wdata   = '0;
    if (cmd.simple) begin
      if (cmd_r == sfl_pkg::CMD_COMPACT) begin
        we    = total != '0;
        wdata = {total, compact_base};
      end else begin
        we    = init_ok;
        wdata = {mem_size - res_size, AB'(res_size)};
      end
    end else if (cmd.decide) begin
      if (cmd_r == sfl_pkg::CMD_ALLOC) begin
        we      = found && carve;
        waddr_w = pick_idx;
        wdata   = {pick_len - size_r, carve_base};
      end else if (rel_ok && jp) begin
        we      = 1'b1;
        waddr_w = CW'(p - CW'(1));
        wdata   = {merged_len, prev_base};
      end else if (rel_ok && jn) begin
        we      = 1'b1;
        waddr_w = p;
        wdata   = {jn_len, base_r};
      end
    end else if (rd_valid && cmd.shift_dn) begin
      we      = 1'b1;
      waddr_w = CW'(rd_idx - CW'(1));
      wdata   = rdata;
    end else if (rd_valid && cmd.shift_up) begin
      we      = 1'b1;
      waddr_w = CW'(rd_idx + CW'(1));
      wdata   = rdata;
    end else if (cmd.shift_up && !sh_more) begin
      we      = 1'b1;
      waddr_w = p;
      wdata   = {size_r, base_r};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
      policy    <= sfl_pkg::FIRST;
      mem_size  <= sfl_pkg::MEM_SIZE_RST;
      res_size  <= sfl_pkg::RES_SIZE_RST;
    end else begin
      rd_valid <= rd_issue;
      if (cfg_valid) begin
        case (cfg_index)
          sfl_pkg::CFG_POLICY:   policy   <= cfg_data[1:0];
          sfl_pkg::CFG_MEM_SIZE: mem_size <= cfg_data;
          sfl_pkg::CFG_RES_SIZE: res_size <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end
      if (cmd.simple) begin
        if (cmd_r == sfl_pkg::CMD_COMPACT) begin
          count <= (total != '0) ? CW'(1) : '0;
        end else begin
          count <= init_ok ? CW'(1) : '0;
          total <= init_ok ? mem_size - res_size : '0;
        end
      end
      if (cmd.decide) begin
        if (cmd_r == sfl_pkg::CMD_ALLOC) begin
          if (found) begin
            total <= alloc_total;
          end
        end else if (rel_ok) begin
          total <= sfl_pkg::sat_len({1'b0, total} + {1'b0, size_r});
        end
      end
      if (cmd.shift_dn && !sh_more && !rd_valid) begin
        count <= CW'(count - CW'(1));
      end
      if (cmd.shift_up && !sh_more && !rd_valid) begin
        count <= CW'(count + CW'(1));
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rd_idx <= scan_issue ? idx : sh_idx;
    if (cmd.load) begin
      cmd_r     <= in_command;
      size_r    <= in_size;
      base_r    <= AB'(in_base);
      status_r  <= sfl_pkg::ST_OK;
      granted_r <= '0;
    end
    if (cmd.start_scan) begin
      idx     <= '0;
      found   <= 1'b0;
      p       <= '0;
      stopped <= 1'b0;
    end
    if (scan_issue) begin
      idx <= CW'(idx + CW'(1));
    end
    if (rd_valid && cmd.scan) begin
      if (cmd_r == sfl_pkg::CMD_ALLOC) begin
        if (e_len >= size_r && better) begin
          found     <= 1'b1;
          pick_idx  <= rd_idx;
          pick_base <= e_base;
          pick_len  <= e_len;
        end
      end else if (!stopped) begin
        if (e_base <= base_r) begin
          p         <= CW'(rd_idx + CW'(1));
          prev_base <= e_base;
          prev_len  <= e_len;
        end else begin
          stopped   <= 1'b1;
          next_base <= e_base;
          next_len  <= e_len;
        end
      end
    end
    if (cmd.decide) begin
      if (cmd_r == sfl_pkg::CMD_ALLOC) begin
        if (!found) begin
          status_r <= (total >= size_r) ? sfl_pkg::ST_COMPACT : sfl_pkg::ST_NOMEM;
        end else begin
          granted_r <= pick_base_w[15:0];
        end
        sh_idx  <= CW'(pick_idx + CW'(1));
        sh_more <= CW'(pick_idx + CW'(1)) < count;
      end else begin
        if (!rel_ok) begin
          status_r <= sfl_pkg::ST_FULL;
        end
        if (jp && jn) begin
          sh_idx  <= CW'(p + CW'(1));
          sh_more <= CW'(p + CW'(1)) < count;
        end else begin
          sh_idx  <= CW'(count - CW'(1));
          sh_more <= count > p;
        end
      end
    end
    if (dn_issue) begin
      sh_idx  <= CW'(sh_idx + CW'(1));
      sh_more <= CW'(sh_idx + CW'(1)) < count;
    end
    if (up_issue) begin
      sh_idx  <= CW'(sh_idx - CW'(1));
      sh_more <= sh_idx != p;
    end
    if (cmd.emit) begin
      out_status  <= status_r;
      out_granted <= granted_r;
      out_total   <= total;
    end
  end

endmodule

// ----- hdl/segment_free_list_allocator.sv -----
// Sequence from an accepted word to a valid result word: compact, init and zero-size items
// go from dispatch straight to the result; allocate and release scan the hole table, one
// entry read per cycle on the table RAM port, then decide, and shift the entries that follow
// when a hole is dropped or opened; a held output word stalls the result.
// One word in flight at a time; the next word can be taken once the result is loaded,
// even while that result waits. Reset (rst, synchronous): empty table, free total 0,
// fit policy first fit, memory size 4096, reserved size 128; table RAM contents are kept.
module segment_free_list_allocator #(
  parameter int FREE_SLOTS = 32,
  parameter int ADDR_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [16:0] region_size, [32:17] region_base, rest 0
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [15:0] granted_base, [32:16] free_total, rest 0
  output logic [1:0]  m_axis_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  sfl_pkg::cmd_t cmd;
  sfl_pkg::sts_t sts;
  logic [15:0]   granted;
  logic [16:0]   free_total;

  // config writes are always taken; the block is idle by contract when they come
  assign cfg_ready = 1'b1;

  sfl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  sfl_dp #(
    .FREE_SLOTS(FREE_SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_command (s_axis_tuser),
    .in_size    (s_axis_tdata[16:0]),
    .in_base    (s_axis_tdata[32:17]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_granted(granted),
    .out_total  (free_total)
  );

  assign m_axis_tdata = {7'b0, free_total, granted};

`ifndef SYNTHESIS
  // only one table sweep runs at a time
  a_one_sweep: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.scan, cmd.shift_dn, cmd.shift_up}))
    else $error("overlapping table sweeps");

  // after taking a word the block is busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // a result is only loaded when the output register can take it
  a_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result overwrites pending word");
`endif

endmodule
